// File: design/mfrp_pkg.sv
// shared constants and payload types for the page transpose frame store
`timescale 1ns / 1ps
`default_nettype none

package mfrp_pkg;

   localparam int ADDR_W        = 10;
   localparam int DATA_W        = 8;
   localparam int ROWS_PER_BAND = 8;
   localparam int ROW_SEL_W     = 3;
   localparam int RECIP_SHIFT   = 16;
   localparam int RECIP_W       = RECIP_SHIFT + 1;
   localparam int PROD_W        = ADDR_W + RECIP_W;
   localparam int CMP_W         = 14;

   localparam logic [DATA_W-1:0] HEADER_MAGIC = 8'h03;

   typedef enum logic {
      KIND_WRITE = 1'b0,
      KIND_READ  = 1'b1
   } kind_type;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;

endpackage

`default_nettype wire

// File: design/mfrp_req_if.sv
// request channel: kind, address and write byte with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface mfrp_req_if;
   logic                valid;
   logic                ready;
   logic                kind;
   mfrp_pkg::addr_type  addr;
   mfrp_pkg::data_type  wdata;

   modport source (output valid, output kind, output addr, output wdata, input ready);
   modport sink   (input valid, input kind, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: design/mfrp_rsp_if.sv
// response channel: read byte and address error flag with valid/ready
`timescale 1ns / 1ps
`default_nettype none

interface mfrp_rsp_if;
   logic                valid;
   logic                ready;
   mfrp_pkg::data_type  rdata;
   logic                addr_error;

   modport source (output valid, output rdata, output addr_error, input ready);
   modport sink   (input valid, input rdata, input addr_error, output ready);
endinterface

`default_nettype wire

// File: design/mono_frame_row_to_page_transpose_top.sv
// Frame store that turns a row-major 1bpp image into vertical LCD page bytes.
// Channels: req_ch carries kind (write image byte / read LCD byte), addr and
// wdata; rsp_ch returns one transfer per request with rdata and addr_error.
// A write stores the byte at the image address; its response has rdata 0.
// A read returns LCD byte addr: header bytes first (byte 0 is 0x03, the rest
// zero), then page bytes gathered from eight pixel rows of one band.
// Out-of-range addresses set addr_error; writes are dropped, reads give 0.
// Storage is eight row banks of BANDS*WIDTH_BYTES bytes, one bank per pixel
// row within a band, so one page byte is one read of all banks in parallel.
// Timing: a request is taken when the block is idle; it then steps through
// the MUL, ACCESS and DONE states, the response is registered as DONE is
// left; only then can the next request be taken. The steps are: reciprocal
// multiply for the image row, bank write or read, gather into the output.
// A stalled response sits in the output register while the next request is
// already taken and processed; it waits to load until the register frees.
// Reset clears the control state and the output valid; image contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module mono_frame_row_to_page_transpose_top #(
   parameter int WIDTH_BYTES  = 20,
   parameter int BANDS        = 6,
   parameter int HEADER_BYTES = 32
) (
   input  wire        clock,
   input  wire        reset,
   mfrp_req_if.sink   req_ch,
   mfrp_rsp_if.source rsp_ch
);

   localparam int ROWS     = mfrp_pkg::ROWS_PER_BAND;
   localparam int IMG_SIZE = WIDTH_BYTES * ROWS * BANDS;
   localparam int LCD_SIZE = HEADER_BYTES + IMG_SIZE;
   localparam int DEPTH    = BANDS * WIDTH_BYTES;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RECIP    = ((1 << mfrp_pkg::RECIP_SHIFT) + WIDTH_BYTES - 1) / WIDTH_BYTES;
   localparam int AW       = mfrp_pkg::ADDR_W;
   localparam int DW       = mfrp_pkg::DATA_W;
   localparam int SW       = mfrp_pkg::ROW_SEL_W;
   localparam int PW       = mfrp_pkg::PROD_W;
   localparam int CW       = mfrp_pkg::CMP_W;
   localparam int MW       = AW + 7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACCESS,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic               kind_ff;
   logic [AW-1:0]      addr_ff;
   logic [DW-1:0]      wdata_ff;
   logic [AW-1:0]      quot_ff;
   logic               err_ff;
   logic               hdr_ff;
   logic               magic_ff;
   logic [SW-1:0]      bit_sel_ff;
   logic               rsp_valid_ff;
   logic [DW-1:0]      rsp_rdata_ff;
   logic               rsp_err_ff;
   logic [DW-1:0]      rd_data_ff [ROWS];

   logic               req_xfer;
   logic               rsp_free;
   logic               rsp_load;
   logic [PW-1:0]      recip_prod;
   logic [AW-1:0]      quot_in;
   logic               is_read;
   logic               wr_range;
   logic               rd_hdr;
   logic               rd_range;
   logic [AW-1:0]      scaled;
   logic [MW-1:0]      row_prod;
   logic [AW-1:0]      wr_entry;
   logic [AW-1:0]      rd_off;
   logic [AW-1:0]      rd_entry;
   logic               wr_en;
   logic               rd_en;
   logic [SW-1:0]      wr_row;
   logic [IDX_W-1:0]   wr_idx;
   logic [IDX_W-1:0]   rd_idx;
   logic [DW-1:0]      gathered;
   logic [DW-1:0]      rdata_in;

   assign req_xfer      = req_ch.valid && (state_ff == ST_IDLE);
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load      = (state_ff == ST_DONE) && rsp_free;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.rdata      = rsp_rdata_ff;
   assign rsp_ch.addr_error = rsp_err_ff;

   // image row index = addr / WIDTH_BYTES by reciprocal multiply (exact for 10-bit addr)
   assign recip_prod = PW'(req_ch.addr) * PW'(RECIP);
   assign quot_in    = recip_prod[mfrp_pkg::RECIP_SHIFT +: AW];

   // address decode and bank entry mapping
   always_comb begin
      is_read  = (kind_ff == mfrp_pkg::KIND_READ);
      wr_range = CW'(addr_ff) < CW'(IMG_SIZE);
      rd_hdr   = CW'(addr_ff) < CW'(HEADER_BYTES);
      rd_range = CW'(addr_ff) < CW'(LCD_SIZE);
      // entry = band*W + byte = addr - (band*7 + row)*W
      scaled   = quot_ff - (quot_ff >> SW);
      row_prod = MW'(scaled) * MW'(WIDTH_BYTES);
      wr_entry = addr_ff - row_prod[AW-1:0];
      wr_row   = quot_ff[SW-1:0];
      // page byte offset: every 8 columns of a band map to one bank entry
      rd_off   = addr_ff - AW'(HEADER_BYTES);
      rd_entry = rd_off >> SW;
      wr_idx   = wr_entry[IDX_W-1:0];
      rd_idx   = rd_entry[IDX_W-1:0];
      wr_en    = (state_ff == ST_ACCESS) && !is_read && wr_range;
      rd_en    = (state_ff == ST_ACCESS) && is_read && !rd_hdr && rd_range;
   end

   // eight row banks, one write port and one registered read port each
   for (genvar g = 0; g < ROWS; g++) begin : g_bank
      logic [DW-1:0] bank_mem [DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_row == SW'(g))) begin
            bank_mem[wr_idx] <= wdata_ff;
         end
         if (rd_en) begin
            rd_data_ff[g] <= bank_mem[rd_idx];
         end
      end
   end

   // gather one pixel column: bit 7-c%8 of each row byte, row r at bit r
   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         gathered[r] = rd_data_ff[r][~bit_sel_ff];
      end
      if ((kind_ff == mfrp_pkg::KIND_WRITE) || err_ff) begin
         rdata_in = '0;
      end else if (hdr_ff) begin
         rdata_in = magic_ff ? mfrp_pkg::HEADER_MAGIC : '0;
      end else begin
         rdata_in = gathered;
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output valid: set on load, cleared once the transfer completes
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  kind_ff  <= req_ch.kind;
                  addr_ff  <= req_ch.addr;
                  wdata_ff <= req_ch.wdata;
                  quot_ff  <= quot_in;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACCESS;
            end
            ST_ACCESS: begin
               err_ff     <= is_read ? !rd_range : !wr_range;
               hdr_ff     <= rd_hdr;
               magic_ff   <= (addr_ff == '0);
               bit_sel_ff <= rd_off[SW-1:0];
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_rdata_ff <= rdata_in;
                  rsp_err_ff   <= err_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_wr_in_bounds: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_entry) < DEPTH))
      else $error("bank write entry beyond depth");

   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_MUL))
      else $error("accepted request did not start processing");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished item not loaded into output register");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> (rsp_rdata_ff == '0))
      else $error("address error response carries nonzero data");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench for the row-to-page transpose frame store: queued transfers checked by a predictor
`timescale 1ns / 1ps

module testbench;

   localparam int WIDTH_BYTES   = 20;
   localparam int BANDS         = 6;
   localparam int HEADER_BYTES  = 32;
   localparam int BAND_SPAN     = WIDTH_BYTES * mfrp_pkg::ROWS_PER_BAND;
   localparam int IMG_BYTES     = BAND_SPAN * BANDS;
   localparam int LCD_BYTES     = HEADER_BYTES + IMG_BYTES;
   localparam int MSB_PIXEL     = 7;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      mfrp_pkg::kind_type kind;
      mfrp_pkg::addr_type addr;
      mfrp_pkg::data_type wdata;
   } page_req_type;

   typedef struct packed {
      mfrp_pkg::data_type rdata;
      logic               addr_error;
   } page_rsp_type;

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_HOLD
   } rx_mode_type;

   logic clock;
   logic reset;

   mfrp_req_if req_ch ();
   mfrp_rsp_if rsp_ch ();

   mono_frame_row_to_page_transpose_top #(
      .WIDTH_BYTES  (WIDTH_BYTES),
      .BANDS        (BANDS),
      .HEADER_BYTES (HEADER_BYTES)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // stimulus, predictor state and scoreboard
   page_req_type       pending_requests[$];
   page_rsp_type       lcd_results_due[$];
   mfrp_pkg::data_type image_shadow [0:IMG_BYTES-1];
   bit                 stim_written [0:IMG_BYTES-1];
   logic               req_taken;
   int                 fail_count;
   int                 cycle_count;
   int                 gap_left;
   int                 burst_left;
   rx_mode_type        rx_mode;
   int                 rx_mode_left;
   int                 rx_hold_left;

   // first image byte of the eight-row group behind one page byte
   function automatic int group_base(int off);
      return (off / BAND_SPAN) * BAND_SPAN + (off % BAND_SPAN) / 8;
   endfunction

   function automatic bit group_written(int off);
      int base;
      base = group_base(off);
      for (int r = 0; r < mfrp_pkg::ROWS_PER_BAND; r++) begin
         if (!stim_written[base + r * WIDTH_BYTES]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // expected response for one accepted request; writes update the image copy
   function automatic page_rsp_type transpose_access(page_req_type rq);
      page_rsp_type rs;
      int           off;
      int           base;
      int           bit_pos;
      rs.rdata      = '0;
      rs.addr_error = 1'b0;
      if (rq.kind == mfrp_pkg::KIND_WRITE) begin
         if (rq.addr < IMG_BYTES) image_shadow[rq.addr] = rq.wdata;
         else rs.addr_error = 1'b1;
      end else if (rq.addr < HEADER_BYTES) begin
         rs.rdata = (rq.addr == 0) ? mfrp_pkg::HEADER_MAGIC : '0;
      end else if (rq.addr < LCD_BYTES) begin
         off     = rq.addr - HEADER_BYTES;
         base    = group_base(off);
         bit_pos = MSB_PIXEL - (off % BAND_SPAN) % 8;
         for (int r = 0; r < mfrp_pkg::ROWS_PER_BAND; r++) begin
            rs.rdata[r] = image_shadow[base + r * WIDTH_BYTES][bit_pos];
         end
      end else begin
         rs.addr_error = 1'b1;
      end
      return rs;
   endfunction

   task automatic queue_item(mfrp_pkg::kind_type kind, int addr, int wdata);
      page_req_type rq;
      rq.kind  = kind;
      rq.addr  = mfrp_pkg::addr_type'(addr);
      rq.wdata = mfrp_pkg::data_type'(wdata);
      pending_requests.insert(pending_requests.size(), rq);
      if (kind == mfrp_pkg::KIND_WRITE && addr < IMG_BYTES) stim_written[addr] = 1'b1;
   endtask

   // write all eight rows behind one page byte
   task automatic queue_group_writes(int off);
      int base;
      base = group_base(off);
      for (int r = 0; r < mfrp_pkg::ROWS_PER_BAND; r++) begin
         queue_item(mfrp_pkg::KIND_WRITE, base + r * WIDTH_BYTES, $urandom_range(0, 255));
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // request driver: bursts of random length with random gaps
   always @(negedge clock) begin : drive_requests
      page_req_type rq;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (gap_left != 0) begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            rq = pending_requests.pop_front();
            req_ch.kind  <= rq.kind;
            req_ch.addr  <= rq.addr;
            req_ch.wdata <= rq.wdata;
            req_ch.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready: open, coin-flip or long holds, switching every so often
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_type'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(32, 256);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            RX_OPEN: begin
               rsp_ch.ready <= 1'b1;
            end
            RX_COIN: begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (rx_hold_left != 0) begin
                  rsp_ch.ready <= 1'b0;
                  rx_hold_left <= rx_hold_left - 1;
               end else begin
                  rsp_ch.ready <= 1'b1;
                  if ($urandom_range(0, 7) == 0) rx_hold_left <= $urandom_range(1, 16);
               end
            end
         endcase
      end
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin : watch_transfers
      page_req_type rq;
      page_rsp_type due;
      cycle_count = cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            rq.kind  = mfrp_pkg::kind_type'(req_ch.kind);
            rq.addr  = req_ch.addr;
            rq.wdata = req_ch.wdata;
            lcd_results_due.insert(lcd_results_due.size(), transpose_access(rq));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lcd_results_due.size() == 0) begin
               $error("unexpected response transfer: rdata %0h addr_error %0b",
                      rsp_ch.rdata, rsp_ch.addr_error);
               fail_count = fail_count + 1;
            end else begin
               due = lcd_results_due.pop_front();
               if (rsp_ch.rdata !== due.rdata) begin
                  $error("rdata mismatch: expected %0h, got %0h", due.rdata, rsp_ch.rdata);
                  fail_count = fail_count + 1;
               end
               if (rsp_ch.addr_error !== due.addr_error) begin
                  $error("addr_error mismatch: expected %0b, got %0b",
                         due.addr_error, rsp_ch.addr_error);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end

   // stimulus build, reset and end of run
   initial begin : main_flow
      logic [7:0] edge_data [0:7];
      int         queued;
      int         pick;
      int         off;
      int         base;
      bit         found;
      bit         timed_out;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.kind  = mfrp_pkg::KIND_WRITE;
      req_ch.addr  = '0;
      req_ch.wdata = '0;
      rsp_ch.ready = 1'b0;
      req_taken    = 1'b0;
      fail_count   = 0;
      cycle_count  = 0;
      gap_left     = 0;
      burst_left   = 1;
      rx_mode      = RX_OPEN;
      rx_mode_left = 64;
      rx_hold_left = 0;
      for (int i = 0; i < IMG_BYTES; i++) begin
         image_shadow[i] = '0;
         stim_written[i] = 1'b0;
      end

      // directed: header bytes, both out-of-range cases, first and last page byte
      edge_data = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'h80, 8'h01, 8'h7F, 8'hFE};
      queue_item(mfrp_pkg::KIND_READ, 0, 8'hFF);
      queue_item(mfrp_pkg::KIND_READ, HEADER_BYTES - 1, 8'h00);
      queue_item(mfrp_pkg::KIND_READ, LCD_BYTES, 8'h5A);
      queue_item(mfrp_pkg::KIND_READ, 1023, 8'hA5);
      queue_item(mfrp_pkg::KIND_WRITE, IMG_BYTES, 8'hFF);
      queue_item(mfrp_pkg::KIND_WRITE, 1023, 8'hFF);
      for (int r = 0; r < mfrp_pkg::ROWS_PER_BAND; r++) begin
         queue_item(mfrp_pkg::KIND_WRITE, r * WIDTH_BYTES, edge_data[r]);
      end
      queue_item(mfrp_pkg::KIND_READ, HEADER_BYTES, 8'h00);
      queue_item(mfrp_pkg::KIND_READ, HEADER_BYTES + 7, 8'hFF);
      queue_group_writes(IMG_BYTES - 1);
      queue_item(mfrp_pkg::KIND_READ, LCD_BYTES - 1, 8'h00);

      // random: mostly write-a-group-then-read-it sequences, plus singles and noise
      queued = 0;
      while (queued < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            off = $urandom_range(0, IMG_BYTES - 1);
            queue_group_writes(off);
            queued = queued + mfrp_pkg::ROWS_PER_BAND;
            base = off - off % 8;
            for (int n = $urandom_range(1, 8); n > 0; n--) begin
               queue_item(mfrp_pkg::KIND_READ, HEADER_BYTES + base + $urandom_range(0, 7),
                          $urandom_range(0, 255));
               queued = queued + 1;
            end
         end else if (pick < 70) begin
            queue_item(mfrp_pkg::KIND_WRITE, $urandom_range(0, IMG_BYTES - 1),
                       $urandom_range(0, 255));
            queued = queued + 1;
         end else if (pick < 85) begin
            found = 1'b0;
            for (int t = 0; t < 16 && !found; t++) begin
               off = $urandom_range(0, IMG_BYTES - 1);
               if (group_written(off)) begin
                  queue_item(mfrp_pkg::KIND_READ, HEADER_BYTES + off, $urandom_range(0, 255));
                  found = 1'b1;
               end
            end
            if (!found) queue_item(mfrp_pkg::KIND_READ, $urandom_range(0, HEADER_BYTES - 1),
                                   $urandom_range(0, 255));
            queued = queued + 1;
         end else begin
            case ($urandom_range(0, 3))
               0: queue_item(mfrp_pkg::KIND_READ, ($urandom_range(0, 3) == 0) ? 0 :
                             $urandom_range(0, HEADER_BYTES - 1), $urandom_range(0, 255));
               1: queue_item(mfrp_pkg::KIND_READ, $urandom_range(LCD_BYTES, 1023),
                             $urandom_range(0, 255));
               2: queue_item(mfrp_pkg::KIND_WRITE, $urandom_range(IMG_BYTES, 1023),
                             $urandom_range(0, 255));
               default: begin
                  // broken sequence: only some rows of a group get written
                  base = group_base($urandom_range(0, IMG_BYTES - 1));
                  for (int r = 0; r < mfrp_pkg::ROWS_PER_BAND; r++) begin
                     if ($urandom_range(0, 1)) begin
                        queue_item(mfrp_pkg::KIND_WRITE, base + r * WIDTH_BYTES,
                                   $urandom_range(0, 255));
                        queued = queued + 1;
                     end
                  end
               end
            endcase
            queued = queued + 1;
         end
      end

      // hold reset, then release it at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every request and response transfer, bounded by the cycle limit
      while ((pending_requests.size() != 0 || req_ch.valid || lcd_results_due.size() != 0)
             && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      timed_out = (cycle_count >= CYCLE_LIMIT);

      if (timed_out) begin
         $display("CHECKS FAILED");
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (fail_count == 0 && lcd_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
         end else begin
            $display("CHECKS FAILED");
         end
      end
      $finish;
   end

endmodule
